### rtl/bca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bca_pkg
// shared constants, codes and scan types for the bitmap allocator
// ----------------------------------------------------------------------------
package bca_pkg;

  localparam int MEM_WORDS = 256;
  localparam int ROW_BITS  = 8;
  localparam int ROWS      = MEM_WORDS / ROW_BITS;
  localparam int ROW_AW    = $clog2(ROWS);
  localparam int BIT_AW    = $clog2(ROW_BITS);
  localparam int ADDR_W    = $clog2(MEM_WORDS);
  localparam int LEN_W     = ADDR_W + 1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_NEXT  = 2'd1;
  localparam logic [1:0] FIT_BEST  = 2'd2;
  localparam logic [1:0] FIT_WORST = 2'd3;

  localparam logic [1:0] STAT_DONE   = 2'd0;
  localparam logic [1:0] STAT_NO_FIT = 2'd1;
  localparam logic [1:0] STAT_RANGE  = 2'd2;

  typedef struct packed {
    logic              found;
    logic [LEN_W-1:0]  run;
    logic [LEN_W-1:0]  best_len;
    logic [ADDR_W-1:0] start;
  } scan_t;

  // candidate run for best or worst fit, ties keep the earlier run
  function automatic scan_t take_run(scan_t s, logic [LEN_W-1:0] run,
                                     logic [LEN_W-1:0] size, logic want_small,
                                     logic [ADDR_W-1:0] start);
    scan_t r;
    r = s;
    if (run >= size &&
        (!s.found || (want_small ? (run < s.best_len) : (run > s.best_len)))) begin
      r.found    = 1'b1;
      r.best_len = run;
      r.start    = start;
    end
    return r;
  endfunction

endpackage

### rtl/bca_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bca_ram
// generic simple dual-port ram, one write port, registered read
// ----------------------------------------------------------------------------
module bca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/bca_row_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bca_row_scan
// advances the free-run search over one map row
// ----------------------------------------------------------------------------
module bca_row_scan (
  input  logic [bca_pkg::ROW_BITS-1:0] row_bits,
  input  logic [bca_pkg::ROW_AW-1:0]   row_idx,
  input  logic [1:0]                   fit_mode,
  input  logic [bca_pkg::LEN_W-1:0]    block_size,
  input  logic                         mask_en,
  input  logic [bca_pkg::LEN_W-1:0]    mask_ptr,
  input  bca_pkg::scan_t               st_i,
  output bca_pkg::scan_t               st_o
);
  import bca_pkg::*;

  always_comb begin
    scan_t             st;
    logic [ADDR_W-1:0] idx;
    logic              occ;
    st = st_i;
    for (int j = 0; j < ROW_BITS; j++) begin
      idx = {row_idx, BIT_AW'(j)};
      // words below the next-fit pointer count as taken in the first pass
      occ = row_bits[j] | (mask_en && ({1'b0, idx} < mask_ptr));
      if (!occ) begin
        st.run = st.run + 1'b1;
        if (!fit_mode[1] && !st.found && st.run == block_size) begin
          st.found = 1'b1;
          st.start = ADDR_W'({1'b0, idx} + 1'b1 - block_size);
        end
      end else begin
        if (fit_mode[1]) begin
          st = take_run(st, st.run, block_size, fit_mode == FIT_BEST,
                        ADDR_W'({1'b0, idx} - st.run));
        end
        st.run = '0;
      end
    end
    st_o = st;
  end

endmodule

### rtl/bitmap_contiguous_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_contiguous_allocator
// contiguous run allocator over a one-bit-per-word occupancy map
//
//  channel  ports                                      handshake
//  in       in_opcode in_block_size in_free_start      start & !busy
//  out      out_status out_block_start out_block_limit out_strobe, one cycle
//  cfg      cfg_fit_mode                               cfg_valid & cfg_ready
//
// map held in a ram of 32 rows of 8 bits, one row scanned per cycle
// allocate: row scan (second pass for next fit with wrap), then a read and
// a write per row set; free: strobed from idle if rejected or empty, else a
// read and write per row touched; reset clears all 32 rows while busy is high
// results cannot be stalled; cfg is taken only while idle
// ----------------------------------------------------------------------------
module bitmap_contiguous_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_opcode,
  input  logic [bca_pkg::LEN_W-1:0]   in_block_size,
  input  logic [bca_pkg::ADDR_W-1:0]  in_free_start,
  output logic                        out_strobe,
  output logic [1:0]                  out_status,
  output logic [bca_pkg::ADDR_W-1:0]  out_block_start,
  output logic [bca_pkg::LEN_W-1:0]   out_block_limit,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_fit_mode
);
  import bca_pkg::*;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_UPD_RD, S_UPD_WR} state_t;

  state_t              state_r, state_nxt;
  logic [1:0]          mode_r, mode_nxt;
  logic [LEN_W-1:0]    ptr_r, ptr_nxt;
  logic [ROW_AW-1:0]   row_r, row_nxt;
  logic [LEN_W-1:0]    size_r, size_nxt;
  logic [ADDR_W-1:0]   lo_r, lo_nxt;
  logic [LEN_W-1:0]    hi_r, hi_nxt;
  logic                set_r, set_nxt;
  logic                mask_r, mask_nxt;
  scan_t               st_r, st_nxt, st_row, st_end;
  logic                strb_r, strb_nxt;
  logic [1:0]          stat_r, stat_nxt;
  logic [ADDR_W-1:0]   bstart_r, bstart_nxt;
  logic [LEN_W-1:0]    blimit_r, blimit_nxt;

  logic                we;
  logic [ROW_AW-1:0]   raddr;
  logic [ROW_BITS-1:0] rdata, wdata, upd_row;
  logic [LEN_W:0]      free_end;
  logic [LEN_W-1:0]    hi_last;
  logic [ADDR_W-1:0]   idx;

  bca_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (row_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  bca_row_scan u_scan (
    .row_bits   (rdata),
    .row_idx    (row_r),
    .fit_mode   (mode_r),
    .block_size (size_r),
    .mask_en    (mask_r),
    .mask_ptr   (ptr_r),
    .st_i       (st_r),
    .st_o       (st_row)
  );

  assign busy            = (state_r != S_IDLE);
  assign cfg_ready       = (state_r == S_IDLE);
  assign out_strobe      = strb_r;
  assign out_status      = stat_r;
  assign out_block_start = bstart_r;
  assign out_block_limit = blimit_r;

  assign free_end = {2'b00, in_free_start} + {1'b0, in_block_size};
  assign hi_last  = hi_r - 1'b1;
  // run still open at the top of the map
  assign st_end   = take_run(st_row, st_row.run, size_r, mode_r == FIT_BEST,
                             ADDR_W'(LEN_W'(MEM_WORDS) - st_row.run));

  always_comb begin
    upd_row = rdata;
    for (int j = 0; j < ROW_BITS; j++) begin
      idx = {row_r, BIT_AW'(j)};
      if (idx >= lo_r && {1'b0, idx} < hi_r) begin
        upd_row[j] = set_r;
      end
    end
  end

  always_comb begin
    unique case (state_r)
      S_SCAN:   raddr = row_r + 1'b1;
      S_UPD_RD: raddr = row_r;
      default:  raddr = '0;
    endcase
    we    = (state_r == S_CLEAR) || (state_r == S_UPD_WR);
    wdata = (state_r == S_CLEAR) ? '0 : upd_row;
  end

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    ptr_nxt    = ptr_r;
    row_nxt    = row_r;
    size_nxt   = size_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    set_nxt    = set_r;
    mask_nxt   = mask_r;
    st_nxt     = st_r;
    strb_nxt   = 1'b0;
    stat_nxt   = stat_r;
    bstart_nxt = bstart_r;
    blimit_nxt = blimit_r;

    unique case (state_r)
      S_CLEAR: begin
        row_nxt = row_r + 1'b1;
        if (row_r == ROW_AW'(ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cfg_valid) begin
          mode_nxt = cfg_fit_mode;
        end
        if (start) begin
          size_nxt   = in_block_size;
          bstart_nxt = '0;
          blimit_nxt = '0;
          if (in_opcode == OP_FREE) begin
            if (free_end > (LEN_W+1)'(MEM_WORDS)) begin
              strb_nxt = 1'b1;
              stat_nxt = STAT_RANGE;
            end else begin
              if (mode_r == FIT_NEXT && free_end == {1'b0, ptr_r}) begin
                ptr_nxt = {1'b0, in_free_start};
              end
              if (in_block_size == '0) begin
                strb_nxt = 1'b1;
                stat_nxt = STAT_DONE;
              end else begin
                lo_nxt    = in_free_start;
                hi_nxt    = free_end[LEN_W-1:0];
                set_nxt   = 1'b0;
                row_nxt   = in_free_start[ADDR_W-1:BIT_AW];
                state_nxt = S_UPD_RD;
              end
            end
          end else begin
            if (in_block_size == '0 || in_block_size > LEN_W'(MEM_WORDS)) begin
              strb_nxt = 1'b1;
              stat_nxt = STAT_NO_FIT;
            end else begin
              row_nxt   = '0;
              st_nxt    = '0;
              mask_nxt  = (mode_r == FIT_NEXT);
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        row_nxt = row_r + 1'b1;
        st_nxt  = st_row;
        if (!mode_r[1] && st_row.found) begin
          lo_nxt    = st_row.start;
          hi_nxt    = LEN_W'({1'b0, st_row.start} + size_r);
          set_nxt   = 1'b1;
          row_nxt   = st_row.start[ADDR_W-1:BIT_AW];
          state_nxt = S_UPD_RD;
          if (mode_r == FIT_NEXT) begin
            ptr_nxt = LEN_W'({1'b0, st_row.start} + size_r);
          end
        end else if (row_r == ROW_AW'(ROWS - 1)) begin
          if (mode_r[1] && st_end.found) begin
            lo_nxt    = st_end.start;
            hi_nxt    = LEN_W'({1'b0, st_end.start} + size_r);
            set_nxt   = 1'b1;
            row_nxt   = st_end.start[ADDR_W-1:BIT_AW];
            state_nxt = S_UPD_RD;
          end else if (mask_r) begin
            // wrap: second pass from word zero with a fresh run count
            mask_nxt = 1'b0;
            st_nxt   = '0;
          end else begin
            strb_nxt   = 1'b1;
            stat_nxt   = STAT_NO_FIT;
            bstart_nxt = '0;
            blimit_nxt = '0;
            state_nxt  = S_IDLE;
          end
        end
      end
      S_UPD_RD: begin
        state_nxt = S_UPD_WR;
      end
      S_UPD_WR: begin
        row_nxt = row_r + 1'b1;
        if (row_r == hi_last[ADDR_W-1:BIT_AW]) begin
          strb_nxt   = 1'b1;
          stat_nxt   = STAT_DONE;
          bstart_nxt = set_r ? lo_r : '0;
          blimit_nxt = set_r ? hi_r : '0;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_UPD_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      mode_r  <= FIT_FIRST;
      ptr_r   <= '0;
      row_r   <= '0;
      strb_r  <= 1'b0;
      mask_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      ptr_r   <= ptr_nxt;
      row_r   <= row_nxt;
      strb_r  <= strb_nxt;
      mask_r  <= mask_nxt;
    end
    size_r   <= size_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    set_r    <= set_nxt;
    st_r     <= st_nxt;
    stat_r   <= stat_nxt;
    bstart_r <= bstart_nxt;
    blimit_r <= blimit_nxt;
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the bitmap contiguous allocator: a directed table
// of allocate and free items, then random traffic in all four fit modes,
// every result compared with a behavioral model of the occupancy map
// ----------------------------------------------------------------------------
module tb;
  import bca_pkg::*;

  localparam int WATCHDOG = 20000;

  typedef struct {
    logic        op;
    logic [8:0]  size;
    logic [7:0]  fstart;
    bit          typed;
    logic [1:0]  st;
    logic [7:0]  bstart;
    logic [8:0]  blimit;
  } row_t;

  typedef struct {
    logic [1:0] st;
    logic [7:0] bstart;
    logic [8:0] blimit;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_opcode = 1'b0;
  logic [8:0] in_block_size = '0;
  logic [7:0] in_free_start = '0;
  logic out_strobe;
  logic [1:0] out_status;
  logic [7:0] out_block_start;
  logic [8:0] out_block_limit;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_fit_mode = '0;

  bit map_used [MEM_WORDS];
  int unsigned fit_ptr;
  logic [1:0] mode;
  alloc_result_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;
  bit no_idle = 0;
  row_t dir[$];

  always #2 clk = ~clk;

  bitmap_contiguous_allocator dut (.*);

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result st=%0d start=%0d limit=%0d", $time,
                 out_status, out_block_start, out_block_limit);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (e.st !== out_status || e.bstart !== out_block_start ||
            e.blimit !== out_block_limit) begin
          $display("%0t mismatch exp st=%0d start=%0d limit=%0d got st=%0d start=%0d limit=%0d",
                   $time, e.st, e.bstart, e.blimit, out_status, out_block_start,
                   out_block_limit);
          errors++;
        end
      end
    end
  end

  function automatic alloc_result_t predict_alloc(logic op, int unsigned size,
                                                  int unsigned fs);
    alloc_result_t r;
    int unsigned run, pos, s, best;
    bit ok, take;
    r = '{STAT_DONE, 8'd0, 9'd0};
    ok = 0;
    s = 0;
    if (op == OP_ALLOC) begin
      if (size != 0 && size <= MEM_WORDS) begin
        run = 0;
        if (mode == FIT_FIRST) begin
          for (int i = 0; i < MEM_WORDS && !ok; i++) begin
            if (!map_used[i]) begin
              run++;
              if (run == size) begin ok = 1; s = i + 1 - size; end
            end else run = 0;
          end
        end else if (mode == FIT_NEXT) begin
          pos = fit_ptr;
          for (int i = 0; i < 2 * MEM_WORDS && !ok; i++) begin
            if (pos >= MEM_WORDS) begin run = 0; pos = 0; end
            if (!map_used[pos]) begin
              run++;
              if (run == size) begin ok = 1; s = pos + 1 - size; end
            end else run = 0;
            pos++;
          end
        end else begin
          best = 0;
          for (int i = 0; i < MEM_WORDS; i++) begin
            if (!map_used[i]) run++;
            else run = 0;
            if (run > 0 && (i == MEM_WORDS - 1 || map_used[i + 1])) begin
              if (run >= size) begin
                take = !ok || (mode == FIT_BEST ? run < best : run > best);
                if (take) begin ok = 1; best = run; s = i + 1 - run; end
              end
              run = 0;
            end
          end
        end
      end
      if (ok) begin
        for (int i = 0; i < size; i++) map_used[s + i] = 1;
        r.bstart = s[7:0];
        r.blimit = 9'(s + size);
        if (mode == FIT_NEXT) fit_ptr = s + size;
      end else r.st = STAT_NO_FIT;
    end else begin
      if (fs + size > MEM_WORDS) r.st = STAT_RANGE;
      else begin
        for (int i = 0; i < size; i++) map_used[fs + i] = 0;
        if (mode == FIT_NEXT && fs + size == fit_ptr) fit_ptr = fs;
      end
    end
    return r;
  endfunction

  task automatic issue(logic op, logic [8:0] size, logic [7:0] fs, bit typed,
                       alloc_result_t want);
    alloc_result_t e;
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_block_size <= size;
    in_free_start <= fs;
    do @(posedge clk); while (busy);
    e = predict_alloc(op, size, fs);
    if (typed && (e.st !== want.st || e.bstart !== want.bstart ||
                  e.blimit !== want.blimit)) begin
      $display("%0t table row disagrees: exp st=%0d start=%0d limit=%0d",
               $time, want.st, want.bstart, want.blimit);
      $display("%0t   model st=%0d start=%0d limit=%0d",
               $time, e.st, e.bstart, e.blimit);
      errors++;
    end
    pending_results.push_back(e);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_mode(logic [1:0] m);
    drain();
    cfg_valid <= 1'b1;
    cfg_fit_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode = m;
  endtask

  task automatic add_row(logic op, int size, int fs, bit typed = 0,
                         logic [1:0] st = 0, int bs = 0, int bl = 0);
    dir.push_back('{op, 9'(size), 8'(fs), typed, st, 8'(bs), 9'(bl)});
  endtask

  task automatic random_item(int max_size);
    logic op;
    int unsigned size, fs, k;
    k = $urandom_range(0, 99);
    op = (k < 55) ? OP_ALLOC : OP_FREE;
    if (k < 3) size = $urandom_range(0, 511);
    else if (k < 8) size = $urandom_range(200, 256);
    else size = $urandom_range(1, max_size);
    fs = $urandom_range(0, 255);
    if (op == OP_FREE && $urandom_range(0, 3) != 0 && fs + size > 256)
      size = 256 - fs;
    issue(op, 9'(size), 8'(fs), 0, '{0, 0, 0});
  endtask

  initial begin
    mode = FIT_FIRST;
    fit_ptr = 0;
    foreach (map_used[i]) map_used[i] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_row(OP_ALLOC, 0, 0, 1, STAT_NO_FIT, 0, 0);
    add_row(OP_ALLOC, 257, 0, 1, STAT_NO_FIT, 0, 0);
    add_row(OP_ALLOC, 511, 255, 1, STAT_NO_FIT, 0, 0);
    add_row(OP_ALLOC, 256, 0, 1, STAT_DONE, 0, 256);
    add_row(OP_ALLOC, 1, 0, 1, STAT_NO_FIT, 0, 0);
    add_row(OP_FREE, 2, 255, 1, STAT_RANGE, 0, 0);
    add_row(OP_FREE, 511, 1, 1, STAT_RANGE, 0, 0);
    add_row(OP_FREE, 256, 0, 1, STAT_DONE, 0, 0);
    add_row(OP_FREE, 0, 255, 1, STAT_DONE, 0, 0);
    add_row(OP_FREE, 1, 255, 1, STAT_DONE, 0, 0);
    add_row(OP_FREE, 511, 0, 1, STAT_RANGE, 0, 0);
    add_row(OP_ALLOC, 1, 0, 1, STAT_DONE, 0, 1);
    add_row(OP_ALLOC, 10, 0);
    add_row(OP_ALLOC, 3, 0);
    add_row(OP_FREE, 10, 1);
    add_row(OP_ALLOC, 255, 0);
    add_row(OP_FREE, 170, 85);
    foreach (dir[i])
      issue(dir[i].op, dir[i].size, dir[i].fstart, dir[i].typed,
            '{dir[i].st, dir[i].bstart, dir[i].blimit});

    for (int ph = 0; ph < 12; ph++) begin
      set_mode(ph < 4 ? 2'(ph) : 2'($urandom_range(0, 3)));
      for (int n = 0; n < 150; n++) random_item(ph % 3 == 0 ? 64 : 24);
      if (ph == 5) drain();
    end
    set_mode(FIT_NEXT);
    for (int n = 0; n < 100; n++) random_item(16);
    set_mode(FIT_WORST);
    no_idle = 1;
    for (int n = 0; n < 100; n++) random_item(32);

    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
